>>> src/dq_pkg.sv
`timescale 1ns / 1ps
package dq_pkg;

  // Queue geometry
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  // What every cell of the row does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_RIGHT,
    CELL_SHIFT_LEFT,
    CELL_ROTATE,
    CELL_LOAD_BACK
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [CntW-1:0]   count;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DataW-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DataW-1:0]  item;
    logic [CntW-1:0]          occupancy;
    logic                     last;
  } out_t;

endpackage

>>> src/dq_cell.sv
`timescale 1ns / 1ps
module dq_cell (
  input  logic                          clk_i,
  input  logic [dq_pkg::IdxW-1:0]       idx_i,
  input  dq_pkg::cell_ctrl_t            ctrl_i,
  input  logic [dq_pkg::DataW-1:0]      left_i,
  input  logic [dq_pkg::DataW-1:0]      right_i,
  input  logic [dq_pkg::DataW-1:0]      head_i,
  output logic [dq_pkg::DataW-1:0]      data_o
);

  localparam int unsigned CntW = dq_pkg::CntW;

  logic [dq_pkg::DataW-1:0] data_q, data_d;
  logic [CntW-1:0]          idx_ext;
  logic                     is_tail;
  logic                     is_free;

  // Locate this cell against the current fill level
  assign idx_ext = CntW'(idx_i);
  assign is_tail = (idx_ext + CntW'(1)) == ctrl_i.count;
  assign is_free = idx_ext == ctrl_i.count;

  // Select the next value from self, a neighbor, the head or the pushed value
  always_comb begin
    case (ctrl_i.op)
      dq_pkg::CELL_HOLD:        data_d = data_q;
      dq_pkg::CELL_SHIFT_RIGHT: data_d = left_i;
      dq_pkg::CELL_SHIFT_LEFT:  data_d = right_i;
      dq_pkg::CELL_ROTATE:      data_d = is_tail ? head_i : right_i;
      dq_pkg::CELL_LOAD_BACK:   data_d = is_free ? ctrl_i.value : data_q;
      default:                  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> src/double_ended_queue_core.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of 16 signed 32-bit values, held in a row of cells with the
// front element always in the first cell. Push front and pop front shift the whole row by
// one place, push back loads the cell just past the tail, and pop back reads the tail
// cell; each of these yields one transaction on the output. A list command rotates the
// occupied cells through the head once, one element per cycle while the output register is
// free, with one transaction per element, and leaves the order unchanged; the last
// transaction of a list carries last = 1. A single output register holds the pending
// result: a new command is taken while that register is empty or being drained, so
// commands other than list sustain one per cycle. Pushing onto a full queue returns
// status full and changes nothing; popping or listing an empty queue returns status
// empty. Occupancy gives the element count after the command.
module double_ended_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dq_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dq_pkg::out_t  out_data_o
);

  localparam int unsigned Depth = dq_pkg::Depth;
  localparam int unsigned IdxW  = dq_pkg::IdxW;
  localparam int unsigned CntW  = dq_pkg::CntW;
  localparam int unsigned DataW = dq_pkg::DataW;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    remain_q, remain_d;
  logic               out_valid_q, out_valid_d;
  dq_pkg::out_t       out_q, out_d;

  dq_pkg::cell_ctrl_t ctrl;
  dq_pkg::cell_op_e   cell_op;
  logic [DataW-1:0]   cell_data [Depth];
  logic [DataW-1:0]   head_data;
  logic [DataW-1:0]   tail_data;
  logic [IdxW-1:0]    tail_idx;
  logic               out_free;
  logic               accept;
  logic               is_full;
  logic               is_empty;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = count_q == CntW'(Depth);
  assign is_empty   = count_q == '0;
  assign head_data  = cell_data[0];
  assign tail_idx   = IdxW'(count_q - CntW'(1));
  assign tail_data  = cell_data[tail_idx];

  // Decode the command and schedule the cell row
  always_comb begin
    cell_op     = dq_pkg::CELL_HOLD;
    count_d     = count_q;
    remain_d    = remain_q;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (accept) begin
      out_valid_d     = 1'b1;
      out_d.status    = dq_pkg::STS_OK;
      out_d.item      = '0;
      out_d.last      = 1'b1;
      case (in_data_i.cmd)
        dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
          if (is_full) begin
            out_d.status = dq_pkg::STS_FULL;
          end else begin
            cell_op = (in_data_i.cmd == dq_pkg::CMD_PUSH_FRONT) ?
                      dq_pkg::CELL_SHIFT_RIGHT : dq_pkg::CELL_LOAD_BACK;
            count_d = count_q + CntW'(1);
          end
        end
        dq_pkg::CMD_POP_FRONT: begin
          if (is_empty) begin
            out_d.status = dq_pkg::STS_EMPTY;
          end else begin
            cell_op    = dq_pkg::CELL_SHIFT_LEFT;
            out_d.item = head_data;
            count_d    = count_q - CntW'(1);
          end
        end
        dq_pkg::CMD_POP_BACK: begin
          if (is_empty) begin
            out_d.status = dq_pkg::STS_EMPTY;
          end else begin
            out_d.item = tail_data;
            count_d    = count_q - CntW'(1);
          end
        end
        dq_pkg::CMD_LIST: begin
          if (is_empty) begin
            out_d.status = dq_pkg::STS_EMPTY;
          end else begin
            cell_op    = dq_pkg::CELL_ROTATE;
            out_d.item = head_data;
            out_d.last = count_q == CntW'(1);
            remain_d   = count_q - CntW'(1);
            if (count_q != CntW'(1)) begin
              state_d = ST_LIST;
            end
          end
        end
        default: begin
        end
      endcase
      out_d.occupancy = count_d;
    end else if (state_q == ST_LIST && out_free) begin
      // Advance the rotation by one element
      cell_op         = dq_pkg::CELL_ROTATE;
      out_valid_d     = 1'b1;
      out_d.status    = dq_pkg::STS_OK;
      out_d.item      = head_data;
      out_d.occupancy = count_q;
      out_d.last      = remain_q == CntW'(1);
      remain_d        = remain_q - CntW'(1);
      if (remain_q == CntW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  assign ctrl.op    = cell_op;
  assign ctrl.count = count_q;
  assign ctrl.value = in_data_i.value;

  // Row of storage cells, front at index zero
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [DataW-1:0] left_data;
    logic [DataW-1:0] right_data;
    if (g == 0) begin : g_first
      assign left_data = in_data_i.value;
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end
    if (g == Depth - 1) begin : g_lastc
      assign right_data = head_data;
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end
    dq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_data),
      .right_i (right_data),
      .head_i  (head_data),
      .data_o  (cell_data[g])
    );
  end

  // Hold control state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/dq_checker.sv
`timescale 1ns / 1ps
module dq_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_o,
  input  dq_pkg::in_t   in_data_i,
  input  logic          out_valid_o,
  input  logic          out_ready_i,
  input  dq_pkg::out_t  out_data_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Never report more elements than the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.occupancy <= dq_pkg::CntW'(dq_pkg::Depth))
    else $error("occupancy beyond depth");

  // Error results are single, final and carry no item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != dq_pkg::STS_OK |->
      out_data_o.last && out_data_o.item == '0)
    else $error("error result malformed");

  // A list run keeps the occupancy fixed between its transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && out_data_o.occupancy == $past(out_data_o.occupancy))
    else $error("list run broken");

  // Take no command while a list run is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("command taken during list");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);
